// ----- rtl/link_etx_estimator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// link_etx_estimator_unit_macros.svh
// Assertion shorthands used by the checker file of the ETX estimator.
// ----------------------------------------------------------------------------
`ifndef LINK_ETX_ESTIMATOR_UNIT_MACROS_SVH
`define LINK_ETX_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LETX_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LETX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/letx_pkg.sv -----
// ----------------------------------------------------------------------------
// letx_pkg
// Types and constants of the link ETX estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package letx_pkg;

    // Field widths
    localparam int SlotW   = 3;
    localparam int CntW    = 16;
    localparam int EtxW    = 20;
    localparam int WeightW = 9;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int SDataW = 88;
    localparam int MDataW = 24;

    // Datapath widths
    localparam int MulAW  = 20;
    localparam int MulBW  = 17;
    localparam int MulPW  = MulAW + MulBW;
    localparam int NumW   = 41;
    localparam int DenW   = 33;
    localparam int AccW   = 29;
    localparam int DivSteps = 20;
    localparam int DivCntW  = 5;

    // Q12.8 constants
    localparam logic [EtxW-1:0]    EtxOne     = 20'd256;
    localparam logic [EtxW-1:0]    EtxOneHalf = 20'd384;
    localparam logic [EtxW-1:0]    EtxMax     = 20'hFFFFF;
    localparam logic [WeightW-1:0] WeightFull = 9'd256;
    localparam logic [WeightW-1:0] WeightRst  = 9'd192;
    localparam logic [AccW-1:0]    RoundHalf  = 29'd128;

    // Register map: one register index bit above the word offset
    localparam int RegIdxW = 1;
    localparam logic [RegIdxW-1:0] RegEwmaWeight = 1'b0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_DIV_CHK,
        ST_DIV,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_FINISH
    } letx_state_t;

    // Counter moved into Q12.8 with saturation
    function automatic logic [EtxW-1:0] sat_q8(input logic [CntW-1:0] cnt);
        logic [EtxW-1:0] res;
        if (cnt[CntW-1:EtxW-8] != '0) begin
            res = EtxMax;
        end else begin
            res = {cnt[EtxW-9:0], 8'd0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/link_etx_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// link_etx_estimator_unit
// Smoothed ETX per parent slot from per-neighbour link counters.
// ----------------------------------------------------------------------------
// Usage:
// s_* beats carry one neighbour's counter snapshot and its parent slot; every
// beat yields exactly one m_* beat with the slot, its ETX (Q12.8) and a flag
// that says whether the entry was blended.
// The ewma_weight register sits on the APB port at byte address 0.
// Timing: one beat is worked on at a time; s_tready is low from acceptance
// until the result is loaded into the output register. A skipped item goes
// from evaluation straight to write back, a sample without division skips the
// counter products and the divide, and a full sample takes two products on the
// shared 20x17 multiplier, a saturation check, 20 restoring divide steps, two
// blend products and write back. The divider gives one quotient bit per cycle.
// A finished result waits in the output register; while it is stalled by
// m_tready the sequencer holds in its last step and takes no new beat.
// Reset (aresetn low, synchronous) sets every ETX entry to 1.0, the weight to
// 192 and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module link_etx_estimator_unit #(
    parameter int PARENT_SLOTS = 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // APB register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // parent_slot[2:0], net_pkts[18:3], packs_radio[34:19], acks_seen[50:35],
    // drops_seen[66:51], packs_first_try[82:67], zero pad[87:83]
    input  wire  [letx_pkg::SDataW-1:0]  s_tdata,
    // is_parent[0]
    input  wire                          s_tuser,
    // Result stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // slot_out[2:0], etx_value[22:3], zero pad[23]
    output logic [letx_pkg::MDataW-1:0]  m_tdata,
    // was_updated[0]
    output logic                         m_tuser
);

    import letx_pkg::*;

    // Slot is 3 bits wide, so no more than 8 entries are reachable
    localparam int TableDepth = (PARENT_SLOTS < 8) ? PARENT_SLOTS : 8;
    localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;

    // Sequencer and captured item
    letx_state_t          state_reg, state_next;
    logic [SlotW-1:0]     slot_reg, slot_next;
    logic                 parent_reg, parent_next;
    logic [CntW-1:0]      net_reg, net_next;
    logic [CntW-1:0]      tx_reg, tx_next;
    logic [CntW-1:0]      acks_reg, acks_next;
    logic [CntW-1:0]      drops_reg, drops_next;
    logic [CntW-1:0]      once_reg, once_next;

    // Working registers
    logic [EtxW-1:0]      old_reg, old_next;
    logic [EtxW-1:0]      sample_reg, sample_next;
    logic [NumW-1:0]      num_reg, num_next;
    logic [DenW-1:0]      den_reg, den_next;
    logic [DenW-1:0]      rem_reg, rem_next;
    logic [DivCntW-1:0]   cnt_reg, cnt_next;
    logic [AccW-1:0]      acc_reg, acc_next;
    logic                 upd_reg, upd_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [SlotW-1:0]     m_slot_reg, m_slot_next;
    logic [EtxW-1:0]      m_etx_reg, m_etx_next;
    logic                 m_upd_reg, m_upd_next;

    // Configuration and table
    logic [WeightW-1:0]   weight_reg;
    logic [EtxW-1:0]      etx_table_reg [TableDepth];

    // Combinational helpers
    logic [WeightW-1:0]   weight_eff;
    logic [MulAW-1:0]     mul_a;
    logic [MulBW-1:0]     mul_b;
    logic [MulPW-1:0]     prod;
    logic [DenW:0]        trial;
    logic                 trial_ge;
    logic [AccW-8-1:0]    blended;
    logic [EtxW-1:0]      final_val;
    logic                 in_range;
    logic [IdxW-1:0]      tbl_idx;
    logic                 tbl_we;
    logic                 cfg_wr;

    // ------------------------------------------------------------------------
    // APB register port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegEwmaWeight) begin
            prdata = {{(32-WeightW){1'b0}}, weight_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WeightRst;
        end else if (cfg_wr && paddr[2] == RegEwmaWeight) begin
            weight_reg <= pwdata[WeightW-1:0];
        end
    end

    // Weights above one act as one
    assign weight_eff = weight_reg[WeightW-1] ? WeightFull : weight_reg;

    // ------------------------------------------------------------------------
    // Shared multiplier, operands picked by the sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_NUM: begin
                mul_a = MulAW'(tx_reg);
                mul_b = MulBW'(net_reg) + MulBW'(1);
            end
            ST_MUL_DEN: begin
                mul_a = MulAW'(acks_reg);
                mul_b = MulBW'(once_reg) + MulBW'(1);
            end
            ST_MUL_OLD: begin
                mul_a = old_reg;
                mul_b = MulBW'(weight_eff);
            end
            ST_MUL_NEW: begin
                mul_a = sample_reg;
                mul_b = MulBW'(WeightFull - weight_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = MulPW'(mul_a) * MulPW'(mul_b);

    // Divider trial subtract: one quotient bit per step
    assign trial    = {rem_reg, num_reg[DivSteps-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    // Rounded blend, saturated to Q12.8
    assign blended   = acc_reg[AccW-1:8];
    assign final_val = blended[AccW-9] ? EtxMax : blended[EtxW-1:0];

    assign in_range = (int'(slot_reg) < TableDepth);
    assign tbl_idx  = slot_reg[IdxW-1:0];
    assign tbl_we   = (state_reg == ST_FINISH) && upd_reg && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        parent_next  = parent_reg;
        net_next     = net_reg;
        tx_next      = tx_reg;
        acks_next    = acks_reg;
        drops_next   = drops_reg;
        once_next    = once_reg;
        old_next     = old_reg;
        sample_next  = sample_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        upd_next     = upd_reg;
        m_valid_next = m_valid_reg;
        m_slot_next  = m_slot_reg;
        m_etx_next   = m_etx_reg;
        m_upd_next   = m_upd_reg;
        s_tready     = (state_reg == ST_IDLE);

        // Output register drains on its own handshake
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    slot_next   = s_tdata[2:0];
                    net_next    = s_tdata[18:3];
                    tx_next     = s_tdata[34:19];
                    acks_next   = s_tdata[50:35];
                    drops_next  = s_tdata[66:51];
                    once_next   = s_tdata[82:67];
                    parent_next = s_tuser;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                upd_next = 1'b0;
                if (!in_range) begin
                    old_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    old_next = etx_table_reg[tbl_idx];
                    if (!parent_reg || net_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        upd_next = 1'b1;
                        if (tx_reg == '0) begin
                            sample_next = (drops_reg <= CntW'(1)) ? EtxOneHalf
                                                                  : sat_q8(drops_reg);
                            state_next  = ST_MUL_OLD;
                        end else if (acks_reg == '0) begin
                            sample_next = sat_q8(tx_reg);
                            state_next  = ST_MUL_OLD;
                        end else begin
                            state_next = ST_MUL_NUM;
                        end
                    end
                end
            end
            ST_MUL_NUM: begin
                num_next   = {prod[DenW-1:0], 8'd0};
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                den_next   = prod[DenW-1:0];
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK: begin
                // Quotient fits 20 bits only if the upper dividend bits stay below den
                if (DenW'(num_reg[NumW-1:DivSteps]) >= den_reg) begin
                    sample_next = EtxMax;
                    state_next  = ST_MUL_OLD;
                end else begin
                    rem_next   = DenW'(num_reg[NumW-1:DivSteps]);
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial_ge) begin
                    rem_next = DenW'(trial - {1'b0, den_reg});
                end else begin
                    rem_next = trial[DenW-1:0];
                end
                sample_next = {sample_reg[EtxW-2:0], trial_ge};
                num_next    = {num_reg[NumW-2:0], 1'b0};
                cnt_next    = cnt_reg + DivCntW'(1);
                if (cnt_reg == DivCntW'(DivSteps - 1)) begin
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD: begin
                acc_next   = AccW'(prod) + RoundHalf;
                state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                acc_next   = acc_reg + AccW'(prod);
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = slot_reg;
                    m_etx_next   = upd_reg ? final_val : old_reg;
                    m_upd_next   = upd_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        parent_reg <= parent_next;
        net_reg    <= net_next;
        tx_reg     <= tx_next;
        acks_reg   <= acks_next;
        drops_reg  <= drops_next;
        once_reg   <= once_next;
        old_reg    <= old_next;
        sample_reg <= sample_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        upd_reg    <= upd_next;
        m_slot_reg <= m_slot_next;
        m_etx_reg  <= m_etx_next;
        m_upd_reg  <= m_upd_next;
    end

    // ETX table: every entry back to 1.0 on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TableDepth; i++) begin
                etx_table_reg[i] <= EtxOne;
            end
        end else if (tbl_we) begin
            etx_table_reg[tbl_idx] <= final_val;
        end
    end

    // Output ports
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(MDataW-SlotW-EtxW){1'b0}}, m_etx_reg, m_slot_reg};
    assign m_tuser  = m_upd_reg;

endmodule

`default_nettype wire

// ----- rtl/letx_checker.sv -----
// ----------------------------------------------------------------------------
// letx_checker
// Port-level checks of the ETX estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_etx_estimator_unit_macros.svh"

module letx_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [letx_pkg::MDataW-1:0]   m_tdata,
    input wire                          m_tuser
);

    import letx_pkg::*;

    logic s_beat;
    logic m_stall;

    assign s_beat  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // A stalled result beat holds its payload
    `LETX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // One item at a time: input closes right after a beat
    `LETX_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_beat, !s_tready, "input ready right after an accepted beat")

    // The input is still closed in the step after evaluation
    `LETX_ASSERT_NOW(a_busy_two, aclk, aresetn, s_beat, ##2 !s_tready, "input reopened too early")

    // No result can be produced in the cycle after an item is taken
    `LETX_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_beat, !$rose(m_tvalid), "result appeared one cycle after input")

endmodule

bind link_etx_estimator_unit letx_checker u_letx_checker (.*);

`default_nettype wire

// ----- sim/link_etx_estimator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_etx_estimator_unit_tb
// Self-checking bench for the per-slot smoothed ETX estimator.
// A directed table walks the sample branches and the ignore cases after reset,
// then several phases of random counter snapshots run, each under its own
// ewma_weight written over APB while the block is idle. Every accepted input
// beat is run through an in-bench ETX predictor; result beats are compared
// field by field, in order, against the predicted or typed values.
// ----------------------------------------------------------------------------
module link_etx_estimator_unit_tb;

    import letx_pkg::*;

    localparam int NumSlots      = 8;
    localparam int NumPhases     = 6;
    localparam int ItemsPerPhase = 123;
    localparam int NumDirected   = 17;
    localparam int MaxGap        = 10;
    localparam int HoldCycles    = 300;
    localparam int StallLimit    = 2000;
    localparam int DrainCycles   = 40;
    localparam int PressurePhase = 2;

    localparam logic [2:0] WeightAddr = {RegEwmaWeight, 2'b00};
    localparam logic [2:0] SpareAddr  = 3'd4;

    // Counter snapshot of one neighbour
    typedef struct packed {
        logic [SlotW-1:0] slot;
        logic             parent;
        logic [CntW-1:0]  net;
        logic [CntW-1:0]  tx;
        logic [CntW-1:0]  acks;
        logic [CntW-1:0]  drops;
        logic [CntW-1:0]  once;
    } link_counters_t;

    typedef struct packed {
        logic [SlotW-1:0] slot;
        logic [EtxW-1:0]  etx;
        logic             upd;
    } etx_result_t;

    typedef struct packed {
        link_counters_t beat;
        logic           typed;
        logic [EtxW-1:0] etx;
        logic           upd;
    } directed_row_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [MDataW-1:0]   m_tdata;
    logic                m_tuser;

    // Predictor state and scoreboard
    logic [EtxW-1:0]     parent_etx [NumSlots];
    logic [WeightW-1:0]  weight_reg;
    etx_result_t         etx_results_due [$];
    int                  mismatch_count;
    int                  stall_cycles;

    // Typed expectation travels with the beat on the bus
    logic                typed_now;
    etx_result_t         typed_result;

    bit                  burst;
    bit                  hold_req;

    link_etx_estimator_unit #(
        .PARENT_SLOTS (NumSlots)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Directed rows: reset state, ignore cases, every sample branch, extremes
    directed_row_t directed_rows [NumDirected] = '{
        '{'{3'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 20'd256, 1'b0},
        '{'{3'd7, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 20'd256, 1'b0},
        '{'{3'd1, 1'b1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, 20'd288, 1'b1},
        '{'{3'd2, 1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0}, 1'b1, 20'd262336, 1'b1},
        '{'{3'd3, 1'b1, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1, 20'd262336, 1'b1},
        '{'{3'd4, 1'b1, 16'd1, 16'd0, 16'd5, 16'd1, 16'd7}, 1'b0, 20'd0, 1'b0},
        '{'{3'd5, 1'b1, 16'd3, 16'd0, 16'd0, 16'd2, 16'd0}, 1'b0, 20'd0, 1'b0},
        '{'{3'd6, 1'b1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0}, 1'b0, 20'd0, 1'b0},
        '{'{3'd7, 1'b1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0}, 1'b0, 20'd0, 1'b0},
        '{'{3'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0}, 1'b0, 20'd0, 1'b0},
        '{'{3'd1, 1'b1, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF}, 1'b0, 20'd0, 1'b0},
        '{'{3'd2, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 20'd0, 1'b0},
        '{'{3'd2, 1'b0, 16'd5, 16'd3, 16'd2, 16'd0, 16'd1}, 1'b0, 20'd0, 1'b0},
        '{'{3'd3, 1'b1, 16'd0, 16'd5, 16'd5, 16'd5, 16'd5}, 1'b0, 20'd0, 1'b0},
        '{'{3'd5, 1'b1, 16'h8000, 16'h4000, 16'h1234, 16'hABCD, 16'h5555}, 1'b0, 20'd0, 1'b0},
        '{'{3'd0, 1'b1, 16'd10, 16'd12, 16'd9, 16'd0, 16'd4}, 1'b0, 20'd0, 1'b0},
        '{'{3'd6, 1'b1, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 16'h3333}, 1'b0, 20'd0, 1'b0}
    };

    // New ETX sample from the counters, Q12.8, saturated
    function automatic logic [EtxW-1:0] etx_sample(link_counters_t c);
        logic [63:0] q;
        logic [63:0] num;
        logic [63:0] den;
        if (c.tx == '0) begin
            q = (c.drops <= 16'd1) ? 64'(EtxOneHalf) : (64'(c.drops) << 8);
        end else if (c.acks == '0) begin
            q = 64'(c.tx) << 8;
        end else begin
            num = (64'(c.tx) * (64'(c.net) + 64'd1)) << 8;
            den = 64'(c.acks) * (64'(c.once) + 64'd1);
            q   = num / den;
        end
        return (q > 64'(EtxMax)) ? EtxMax : q[EtxW-1:0];
    endfunction

    // Blend the sample into the slot's entry and return the expected beat
    function automatic etx_result_t predict_etx(link_counters_t c);
        logic [63:0] w;
        logic [63:0] old;
        logic [63:0] acc;
        etx_result_t r;
        old    = 64'(parent_etx[c.slot]);
        r.slot = c.slot;
        r.etx  = parent_etx[c.slot];
        r.upd  = 1'b0;
        if (c.parent && c.net != '0) begin
            w   = (weight_reg > WeightFull) ? 64'(WeightFull) : 64'(weight_reg);
            acc = (w * old + (64'd256 - w) * 64'(etx_sample(c)) + 64'd128) >> 8;
            r.etx = (acc > 64'(EtxMax)) ? EtxMax : acc[EtxW-1:0];
            r.upd = 1'b1;
            parent_etx[c.slot] = r.etx;
        end
        return r;
    endfunction

    // Counter value biased toward zero, small values and all ones
    function automatic logic [CntW-1:0] rand_count();
        logic [CntW-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = CntW'($urandom_range(1, 15));
            3:       v = CntW'($urandom_range(0, 255));
            default: v = CntW'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [CntW-1:0] rand_nonzero();
        logic [CntW-1:0] v;
        v = rand_count();
        if (v == '0) begin
            v = CntW'($urandom_range(1, 65535));
        end
        return v;
    endfunction

    // Mostly parent updates through the divide path; the rest skip or take the non-divide samples
    function automatic link_counters_t random_beat();
        link_counters_t c;
        int kind;
        kind     = $urandom_range(0, 19);
        c.slot   = SlotW'($urandom_range(0, NumSlots - 1));
        c.parent = 1'b1;
        c.net    = rand_nonzero();
        c.tx     = rand_nonzero();
        c.acks   = rand_nonzero();
        c.drops  = rand_count();
        c.once   = rand_count();
        if (kind < 2) begin
            c.parent = 1'b0;
            c.net    = rand_count();
        end else if (kind < 4) begin
            c.net = '0;
        end else if (kind < 6) begin
            c.tx = '0;
            if ($urandom_range(0, 1) == 0) begin
                c.drops = CntW'($urandom_range(0, 3));
            end
        end else if (kind < 8) begin
            c.acks = '0;
        end
        return c;
    endfunction

    // Offer one beat after a random gap; returns on the falling edge after acceptance
    task automatic send_beat(input link_counters_t c, input logic typed,
                             input etx_result_t t);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata      <= {5'd0, c.once, c.drops, c.acks, c.tx, c.net, c.slot};
        s_tuser      <= c.parent;
        typed_now    <= typed;
        typed_result <= t;
        s_tvalid     <= 1'b1;
        @(posedge aclk);
        while (!(s_tvalid && s_tready)) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop the input and wait for every outstanding result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (etx_results_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == WeightAddr) begin
            weight_reg = data[WeightW-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] exp);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== exp) begin
            $display("%0t: register read at %0d expected %0h actual %0h",
                     $time, addr, exp, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Scoreboard: predict on input beats, compare on result beats
    always @(posedge aclk) begin : scoreboard
        link_counters_t c;
        etx_result_t    pred;
        etx_result_t    due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.slot   = s_tdata[2:0];
                c.net    = s_tdata[18:3];
                c.tx     = s_tdata[34:19];
                c.acks   = s_tdata[50:35];
                c.drops  = s_tdata[66:51];
                c.once   = s_tdata[82:67];
                c.parent = s_tuser;
                pred = predict_etx(c);
                etx_results_due.push_back(typed_now ? typed_result : pred);
            end
            if (m_tvalid && m_tready) begin
                if (etx_results_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, slot %0d etx %0d upd %0b",
                             $time, m_tdata[2:0], m_tdata[22:3], m_tuser);
                    mismatch_count++;
                end else begin
                    due = etx_results_due.pop_front();
                    if (m_tdata[2:0] !== due.slot) begin
                        $display("%0t: slot_out expected %0d actual %0d",
                                 $time, due.slot, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[22:3] !== due.etx) begin
                        $display("%0t: etx_value (slot %0d) expected %0d actual %0d",
                                 $time, due.slot, due.etx, m_tdata[22:3]);
                        mismatch_count++;
                    end
                    if (m_tuser !== due.upd) begin
                        $display("%0t: was_updated (slot %0d) expected %0b actual %0b",
                                 $time, due.slot, due.upd, m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Result sink: random stalls, one long hold-off when requested
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, MaxGap);
            if (hold_req) begin
                gap      = HoldCycles;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Watchdog on cycles without any accepted beat or register access
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("link_etx_estimator_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence
    initial begin : main_seq
        logic [31:0] phase_weight [NumPhases];
        etx_result_t t;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        typed_now      = 1'b0;
        typed_result   = '0;
        burst          = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        weight_reg     = WeightRst;
        for (int i = 0; i < NumSlots; i++) begin
            parent_etx[i] = EtxOne;
        end
        phase_weight[0] = 32'd0;
        phase_weight[1] = 32'hFFFF_FFFF;          // acts as full weight on the old value
        phase_weight[2] = 32'd255;
        phase_weight[3] = 32'hFFFF_FF00;          // exactly 256
        phase_weight[4] = 32'd1;
        phase_weight[5] = 32'($urandom_range(0, 256));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset value of the weight register
        apb_read_check(WeightAddr, 32'(WeightRst));

        // Directed table
        for (int i = 0; i < NumDirected; i++) begin
            t.slot = directed_rows[i].beat.slot;
            t.etx  = directed_rows[i].etx;
            t.upd  = directed_rows[i].upd;
            send_beat(directed_rows[i].beat, directed_rows[i].typed, t);
        end

        // Random phases, one weight each
        for (int p = 0; p < NumPhases; p++) begin
            wait_idle();
            apb_write(WeightAddr, phase_weight[p]);
            apb_read_check(WeightAddr, 32'(weight_reg));
            if (p == PressurePhase) begin
                // write to an unmapped register must leave the weight alone
                apb_write(SpareAddr, $urandom);
                apb_read_check(WeightAddr, 32'(weight_reg));
                hold_req = 1'b1;
            end
            burst = (p % 2 == 1);
            for (int i = 0; i < ItemsPerPhase; i++) begin
                send_beat(random_beat(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DrainCycles) @(posedge aclk);
        if (mismatch_count == 0 && etx_results_due.size() == 0) begin
            $display("link_etx_estimator_unit test passed");
        end else begin
            $display("link_etx_estimator_unit test failed");
        end
        $finish;
    end

endmodule
